// ===== hdl/p2pp_pkg.sv =====
// Shared types, codes and helpers for the planar-to-packed pixel converter.
package p2pp_pkg;

	// Stream field widths
	localparam int S_DATA_W  = 64;   // packed input fields, padded to whole bytes
	localparam int S_USER_W  = 3;    // operation code
	localparam int ARGB_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 9;

	// Memory word: 8 packed 4-bit pixels, then 8 opacity bits (1 = opaque)
	localparam int LANES     = 8;
	localparam int PIX_BITS  = 4;
	localparam int OPQ_LSB   = LANES * PIX_BITS;
	localparam int MEM_W     = OPQ_LSB + LANES;
	localparam logic [MEM_W-1:0] INIT_WORD = {{LANES{1'b1}}, {OPQ_LSB{1'b0}}};

	// Byte positions are 13 bits wide, so no more words than this are reachable
	localparam int MAX_WORDS  = 8192;
	// Pixel compares are done at this width (16-bit pixel index plus one)
	localparam int PIX_CMP_W  = 17;

	localparam int PALETTE_ENTRIES = 16;
	localparam int PAL_W           = 24;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [CFG_DAT_W-1:0] DIM_RESET = 9'd256;

	// Operation codes
	localparam logic [2:0] OP_PALETTE = 3'd0;
	localparam logic [2:0] OP_CLEAR   = 3'd1;
	localparam logic [2:0] OP_PLANE   = 3'd2;
	localparam logic [2:0] OP_MASK    = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_READ
	} state_t;

	// 6-bit color component to 8 bits: (v << 2) - 1, zero stays zero
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [7:0] c;
		c = {v, 2'b00};
		return (c == 8'd0) ? 8'd0 : c - 8'd1;
	endfunction

endpackage

// ===== hdl/planar_to_packed_pixel_palette_top.sv =====
// Planar-to-packed pixel converter: pixel/opacity memory, palette and control.

// Pixels live in one synchronous memory, eight pixels (4 color bits and one
// opacity bit each) per word, so a plane or mask byte touches exactly one word.
// A plane write, a mask write and a pixel read each first read the word, then
// write it back (or look up the palette and load the output register); a read
// result waits in the read state while the output register is still held by
// the sink. A clear is accepted, reads and writes back each word of its extent
// and drains the last write-back; it covers the first n pixels, where n =
// min(width*height, MAX_PIXELS, 65536), and a zero-sized clear stays idle.
// After reset the memory is swept once to all-zero/opaque, one word per cycle,
// ceil(MAX_PIXELS/8) words (8192 at the default size), capped at 8192 words;
// no item is taken during the sweep, configuration writes are.
module planar_to_packed_pixel_palette_top #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [2:0] operation
	input  logic [p2pp_pkg::S_USER_W-1:0]     s_tuser,
	// [1:0] plane, [14:2] byte_position, [22:15] byte_value, [38:23] pixel_index,
	// [42:39] palette_index, [48:43] red_six, [54:49] green_six, [60:55] blue_six
	input  logic [p2pp_pkg::S_DATA_W-1:0]     s_tdata,
	// Result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] argb_word
	output logic [p2pp_pkg::ARGB_W-1:0]       m_tdata,
	// Configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [p2pp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [p2pp_pkg::CFG_DAT_W-1:0]    cfg_data
);
	import p2pp_pkg::*;

	localparam int WORDS_RAW = (MAX_PIXELS + LANES - 1) / LANES;
	localparam int WORDS     = (WORDS_RAW > MAX_WORDS) ? MAX_WORDS : WORDS_RAW;
	localparam int AW        = $clog2(WORDS);
	localparam int CAP_RAW   = WORDS * LANES;
	localparam int CAP       = (MAX_PIXELS < CAP_RAW) ? MAX_PIXELS : CAP_RAW;
	localparam int CNT_W     = $clog2(CAP + 1);
	localparam logic [PIX_CMP_W-1:0] CAP_L = PIX_CMP_W'(CAP);

	// Input field unpacking
	logic [2:0]  in_op;
	logic [1:0]  in_plane;
	logic [12:0] in_pos;
	logic [7:0]  in_val;
	logic [15:0] in_pix;
	logic [3:0]  in_pal;
	logic [5:0]  in_red, in_green, in_blue;

	assign in_op    = s_tuser;
	assign in_plane = s_tdata[1:0];
	assign in_pos   = s_tdata[14:2];
	assign in_val   = s_tdata[22:15];
	assign in_pix   = s_tdata[38:23];
	assign in_pal   = s_tdata[42:39];
	assign in_red   = s_tdata[48:43];
	assign in_green = s_tdata[54:49];
	assign in_blue  = s_tdata[60:55];

	// State
	state_t               state_q, state_d;
	logic [AW-1:0]        init_addr_q;
	logic [AW-1:0]        clr_addr_q;
	logic [AW-1:0]        clr_last_q;
	logic [CNT_W-1:0]     clr_n_q;
	logic [8:0]           width_q, height_q;
	logic [PAL_W-1:0]     palette_q [PALETTE_ENTRIES];

	// Memory and write-back stage
	logic [MEM_W-1:0]     mem [WORDS];
	logic [MEM_W-1:0]     mem_rdata_q;
	logic                 mem_re, mem_we;
	logic [AW-1:0]        mem_raddr, mem_waddr;
	logic [MEM_W-1:0]     mem_wdata, merged;

	logic                 wb_valid_s1;
	logic [AW-1:0]        wb_addr_s1;
	logic [2:0]           wb_op_s1;
	logic [1:0]           wb_plane_s1;
	logic [LANES-1:0]     wb_bits_s1;
	logic [LANES-1:0]     wb_en_s1;
	logic [LANES-1:0]     clr_lane_en;

	// Read result path
	logic [2:0]           rd_lane_q;
	logic                 rd_inr_q;
	logic                 m_tvalid_q;
	logic [ARGB_W-1:0]    m_tdata_q;
	logic                 out_load;
	logic [ARGB_W-1:0]    argb;
	logic [3:0]           rd_color;

	logic                 accept;
	logic [17:0]          area;
	logic [CNT_W-1:0]     clr_n_next, clr_n_m1;
	logic [LANES-1:0]     lane_inr, val_rev;
	logic                 pix_inr;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Clear extent, saturated to the stored image
	assign area       = width_q * height_q;
	assign clr_n_next = (area > 18'(CAP)) ? CNT_W'(CAP) : CNT_W'(area);
	assign clr_n_m1   = clr_n_next - 1'b1;

	// Per-lane range checks and MSB-first bit order for plane and mask bytes
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_inr[l] = {1'b0, in_pos, 3'(l)} < CAP_L;
			val_rev[l]  = in_val[LANES-1-l];
		end
	end
	assign pix_inr = {1'b0, in_pix} < CAP_L;

	// Next state, input ready, memory read control and output load
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = clr_addr_q;
		out_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				if (init_addr_q == AW'(WORDS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_op)
						OP_CLEAR: begin
							if (clr_n_next != '0)
								state_d = ST_CLEAR;
						end
						OP_PLANE, OP_MASK: begin
							mem_re    = 1'b1;
							mem_raddr = in_pos[AW-1:0];
							state_d   = ST_WRITE;
						end
						OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = in_pix[AW+2:3];
							state_d   = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_re    = 1'b1;
				mem_raddr = clr_addr_q;
				if (clr_addr_q == clr_last_q)
					state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			ST_READ: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	// Lanes of the word under clear that fall below the clear extent
	always_comb begin
		for (int l = 0; l < LANES; l++)
			clr_lane_en[l] = PIX_CMP_W'({wb_addr_s1, 3'(l)}) < PIX_CMP_W'(clr_n_q);
	end

	// Modify step of the read-modify-write
	always_comb begin
		merged = mem_rdata_q;
		for (int l = 0; l < LANES; l++) begin
			case (wb_op_s1)
				OP_PLANE: begin
					if (wb_en_s1[l] && wb_bits_s1[l])
						merged[l*PIX_BITS + int'(wb_plane_s1)] = 1'b1;
				end
				OP_MASK: begin
					if (wb_en_s1[l])
						merged[OPQ_LSB + l] = ~wb_bits_s1[l];
				end
				OP_CLEAR: begin
					if (clr_lane_en[l]) begin
						merged[l*PIX_BITS +: PIX_BITS] = '0;
						merged[OPQ_LSB + l]            = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Write port: reset sweep, else write-back
	assign mem_we    = (state_q == ST_INIT) ||
		(wb_valid_s1 && ((wb_op_s1 == OP_CLEAR) || (|wb_en_s1)));
	assign mem_waddr = (state_q == ST_INIT) ? init_addr_q : wb_addr_s1;
	assign mem_wdata = (state_q == ST_INIT) ? INIT_WORD : merged;

	// Pixel memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= mem[mem_raddr];
	end

	// Read result formatting
	assign rd_color = mem_rdata_q[{rd_lane_q, 2'b00} +: PIX_BITS];
	assign argb = rd_inr_q ?
		{(mem_rdata_q[OPQ_LSB + int'(rd_lane_q)] ? ALPHA_OPAQUE : ALPHA_CLEAR),
		 palette_q[rd_color]} : '0;

	// Control registers, configuration and palette
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_addr_q <= '0;
			clr_addr_q  <= '0;
			wb_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
			width_q     <= DIM_RESET;
			height_q    <= DIM_RESET;
			for (int e = 0; e < PALETTE_ENTRIES; e++)
				palette_q[e] <= '0;
		end else begin
			if (state_q == ST_INIT)
				init_addr_q <= init_addr_q + 1'b1;

			if (accept && (in_op == OP_CLEAR))
				clr_addr_q <= '0;
			else if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;

			wb_valid_s1 <= (accept && ((in_op == OP_PLANE) || (in_op == OP_MASK))) ||
				(state_q == ST_CLEAR);

			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			if (cfg_valid) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (accept && (in_op == OP_PALETTE))
				palette_q[in_pal] <= {widen6(in_red), widen6(in_green), widen6(in_blue)};
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (mem_re) begin
			wb_addr_s1  <= mem_raddr;
			wb_op_s1    <= (state_q == ST_CLEAR) ? OP_CLEAR : in_op;
			wb_plane_s1 <= in_plane;
			wb_bits_s1  <= val_rev;
			wb_en_s1    <= lane_inr;
		end
		if (accept && (in_op == OP_CLEAR)) begin
			clr_n_q    <= clr_n_next;
			clr_last_q <= AW'(clr_n_m1 >> 3);
		end
		if (accept && (in_op == OP_READ)) begin
			rd_lane_q <= in_pix[2:0];
			rd_inr_q  <= pix_inr;
		end
		if (out_load)
			m_tdata_q <= argb;
	end

`ifndef NO_ASSERTIONS
	// A write-back only happens while no new item can be taken
	a_wb_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s1 |-> (state_q == ST_WRITE || state_q == ST_CLEAR))
		else $error("write-back overlaps an accepting state");

	// Every write-back merges data read in the cycle before
	a_wb_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s1 |-> $past(mem_re))
		else $error("write-back without a preceding read");

	// A new result only comes out of the read state
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_READ)
		else $error("result raised outside a pixel read");

	// Read data holds while a read result waits for the output register
	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && m_tvalid_q && !m_tready) |=> $stable(mem_rdata_q))
		else $error("read data changed while result was waiting");
`endif

endmodule
